// ===== sv/superfast_hash_32_macros.svh =====
// ----------------------------------------------------------------------------
// superfast_hash_32 assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SUPERFAST_HASH_32_MACROS_SVH
`define SUPERFAST_HASH_32_MACROS_SVH

// condition must hold at every edge outside reset
`define SFH_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SFH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/sfh_pkg.sv =====
// ----------------------------------------------------------------------------
// sfh_pkg
// Types, sizes and hash arithmetic shared by the hash front and back ends.
// ----------------------------------------------------------------------------
package sfh_pkg;

	localparam int MID_DEPTH = 4;
	localparam int MID_AW    = $clog2(MID_DEPTH);
	localparam int MID_CW    = $clog2(MID_DEPTH + 1);
	localparam int OUT_DEPTH = 8;
	localparam int OUT_AW    = $clog2(OUT_DEPTH);
	localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_START = 2'd1,
		KIND_ZERO  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data;
		logic [15:0] len;
		logic        last;
	} mid_entry_t;

	typedef struct packed {
		logic        valid;
		logic        zero;
		logic [31:0] hash;
		logic [23:0] held;
		logic [1:0]  cnt;
	} fin_req_t;

	function automatic logic [31:0] sext8(input logic [7:0] b);
		return {{24{b[7]}}, b};
	endfunction

	// one mixing round over a full group of four bytes
	function automatic logic [31:0] mix_group(input logic [31:0] h, input logic [23:0] held,
			input logic [7:0] b);
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] h1;
		logic [31:0] t;
		logic [31:0] h2;
		lo = {16'b0, held[15:0]};
		hi = {16'b0, b, held[23:16]};
		h1 = h + lo;
		t  = (hi << 11) ^ h1;
		h2 = (h1 << 16) ^ t;
		return h2 + (h2 >> 11);
	endfunction

	// leftover bytes of an unfinished group
	function automatic logic [31:0] tail_rule(input logic [31:0] h, input logic [23:0] held,
			input logic [1:0] cnt);
		logic [31:0] a;
		a = h;
		case (cnt)
			2'd3: begin
				a = a + {16'b0, held[15:0]};
				a = a ^ (a << 16);
				a = a ^ (sext8(held[23:16]) << 18);
				a = a + (a >> 11);
			end
			2'd2: begin
				a = a + {16'b0, held[15:0]};
				a = a ^ (a << 11);
				a = a + (a >> 17);
			end
			2'd1: begin
				a = a + sext8(held[7:0]);
				a = a ^ (a << 10);
				a = a + (a >> 1);
			end
			default: begin
				a = h;
			end
		endcase
		return a;
	endfunction

	function automatic logic [31:0] aval_a(input logic [31:0] h);
		logic [31:0] a;
		a = h ^ (h << 3);
		a = a + (a >> 5);
		a = a ^ (a << 4);
		return a;
	endfunction

	function automatic logic [31:0] aval_b(input logic [31:0] h);
		logic [31:0] a;
		a = h + (h >> 17);
		a = a ^ (a << 25);
		a = a + (a >> 6);
		return a;
	endfunction

endpackage

// ===== sv/superfast_hash_32.sv =====
// Path: a message's final byte (or a zero-length start item) passes the item queue, group
// mixing, tail rule and two avalanche stages, then waits in the result queue to be popped.
// Throughput: one item per cycle while full is low; one byte per cycle through the group mixing
// register unless a final byte finds all result slots reserved. Results wait in an 8-entry queue;
// input stalls only when the 4-entry item queue is full, which needs all result slots reserved.
// Reset (arst_n low, asynchronous) empties both queues, drops any message in progress.
// ----------------------------------------------------------------------------
// superfast_hash_32
// 32-bit SuperFastHash over a byte stream, one byte per item.
// ----------------------------------------------------------------------------
module superfast_hash_32 import sfh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        start_req,
	input  logic [15:0] message_length,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] hash_value
);

	logic       mid_push;
	mid_entry_t mid_in;
	mid_entry_t mid_out;
	logic       mid_pop;
	logic       mid_empty;
	logic       can_issue;
	fin_req_t   req;

	sfh_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.start_req      (start_req),
		.message_length (message_length),
		.mid_push       (mid_push),
		.mid_entry      (mid_in)
	);

	sfh_mid_q u_mid_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_in),
		.rd_en   (mid_pop),
		.rd_data (mid_out),
		.full    (full),
		.empty   (mid_empty)
	);

	sfh_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.entry     (mid_out),
		.mid_pop   (mid_pop),
		.can_issue (can_issue),
		.req       (req)
	);

	sfh_finish u_finish (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.can_issue  (can_issue),
		.pop        (pop),
		.empty      (empty),
		.hash_value (hash_value)
	);

endmodule

// ===== sv/sfh_front.sv =====
// ----------------------------------------------------------------------------
// sfh_front
// Takes input items, tracks bytes still expected and tags each kept item.
// ----------------------------------------------------------------------------
module sfh_front import sfh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        start_req,
	input  logic [15:0] message_length,
	output logic        mid_push,
	output mid_entry_t  mid_entry
);

	logic [15:0] bytes_left_q;
	logic        accept;

	assign accept = push & ~full;

	always_comb begin
		mid_entry.data = data_byte;
		mid_entry.len  = message_length;
		if (start_req) begin
			mid_entry.kind = (message_length == 16'd0) ? KIND_ZERO : KIND_START;
			mid_entry.last = (message_length == 16'd1);
			mid_push       = accept;
		end else begin
			mid_entry.kind = KIND_BYTE;
			mid_entry.last = (bytes_left_q == 16'd1);
			// a byte with no message open is dropped
			mid_push       = accept & (bytes_left_q != 16'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_left_q <= 16'd0;
		end else if (accept) begin
			if (start_req) begin
				bytes_left_q <= (message_length == 16'd0) ? 16'd0 : message_length - 16'd1;
			end else if (bytes_left_q != 16'd0) begin
				bytes_left_q <= bytes_left_q - 16'd1;
			end
		end
	end

endmodule

// ===== sv/sfh_mid_q.sv =====
// ----------------------------------------------------------------------------
// sfh_mid_q
// Short queue of tagged items between the front and the back end.
// ----------------------------------------------------------------------------
module sfh_mid_q import sfh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr_en,
	input  mid_entry_t wr_data,
	input  logic       rd_en,
	output mid_entry_t rd_data,
	output logic       full,
	output logic       empty
);

	mid_entry_t              mem_q [MID_DEPTH];
	logic [MID_AW-1:0]       wr_ptr_q;
	logic [MID_AW-1:0]       rd_ptr_q;
	logic [MID_CW-1:0]       cnt_q;

	assign full    = (cnt_q == MID_CW'(MID_DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + MID_AW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + MID_AW'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + MID_CW'(1);
				2'b01:   cnt_q <= cnt_q - MID_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/sfh_back.sv =====
// ----------------------------------------------------------------------------
// sfh_back
// Running hash state: packs bytes into groups and mixes each full group.
// ----------------------------------------------------------------------------
`include "superfast_hash_32_macros.svh"

module sfh_back import sfh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       mid_empty,
	input  mid_entry_t entry,
	output logic       mid_pop,
	input  logic       can_issue,
	output fin_req_t   req
);

	logic [31:0] h_q;
	logic [23:0] held_q;
	logic [1:0]  pos_q;

	logic [31:0] base_h;
	logic [23:0] base_held;
	logic [1:0]  base_pos;
	logic [31:0] nh;
	logic [23:0] nheld;
	logic [1:0]  npos;
	logic        produces;

	always_comb begin
		case (entry.kind)
			KIND_START: begin
				base_h    = {16'b0, entry.len};
				base_held = '0;
				base_pos  = '0;
			end
			KIND_BYTE: begin
				base_h    = h_q;
				base_held = held_q;
				base_pos  = pos_q;
			end
			default: begin
				base_h    = '0;
				base_held = '0;
				base_pos  = '0;
			end
		endcase

		nh    = base_h;
		nheld = base_held;
		npos  = base_pos + 2'd1;
		case (base_pos)
			2'd0: nheld = {base_held[23:8], entry.data};
			2'd1: nheld = {base_held[23:16], entry.data, base_held[7:0]};
			2'd2: nheld = {entry.data, base_held[15:0]};
			default: begin
				// fourth byte closes the group
				nh    = mix_group(base_h, base_held, entry.data);
				nheld = '0;
				npos  = '0;
			end
		endcase

		produces = (entry.kind == KIND_ZERO) | entry.last;
		mid_pop  = ~mid_empty & (~produces | can_issue);

		req.valid = mid_pop & produces;
		req.zero  = (entry.kind == KIND_ZERO);
		req.hash  = nh;
		req.held  = nheld;
		req.cnt   = npos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q    <= '0;
			held_q <= '0;
			pos_q  <= '0;
		end else if (mid_pop) begin
			h_q <= nh;
			if (produces) begin
				held_q <= '0;
				pos_q  <= '0;
			end else begin
				held_q <= nheld;
				pos_q  <= npos;
			end
		end
	end

	`SFH_ASSERT_NEXT(a_group_cleared, mid_pop && produces, pos_q == '0 && held_q == '0, "group open")

endmodule

// ===== sv/sfh_finish.sv =====
// ----------------------------------------------------------------------------
// sfh_finish
// Tail rule and avalanche pipeline feeding the result queue.
// ----------------------------------------------------------------------------
`include "superfast_hash_32_macros.svh"

module sfh_finish import sfh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fin_req_t    req,
	output logic        can_issue,
	input  logic        pop,
	output logic        empty,
	output logic [31:0] hash_value
);

	logic              v_s1;
	logic              zero_s1;
	logic [31:0]       h_s1;
	logic [23:0]       held_s1;
	logic [1:0]        cnt_s1;
	logic              v_s2;
	logic [31:0]       h_s2;
	logic              v_s3;
	logic [31:0]       h_s3;

	logic [31:0]       mem_q [OUT_DEPTH];
	logic [OUT_AW-1:0] wr_ptr_q;
	logic [OUT_AW-1:0] rd_ptr_q;
	logic [OUT_CW-1:0] cnt_q;
	// slots taken by items in flight plus items queued
	logic [OUT_CW-1:0] resv_q;
	logic              pop_ok;

	assign empty      = (cnt_q == '0);
	assign hash_value = mem_q[rd_ptr_q];
	assign pop_ok     = pop & ~empty;
	assign can_issue  = (resv_q < OUT_CW'(OUT_DEPTH));

	always_ff @(posedge clk) begin
		zero_s1 <= req.zero;
		h_s1    <= req.hash;
		held_s1 <= req.held;
		cnt_s1  <= req.cnt;
		h_s2    <= zero_s1 ? 32'd0 : tail_rule(h_s1, held_s1, cnt_s1);
		h_s3    <= aval_a(h_s2);
		if (v_s3) begin
			mem_q[wr_ptr_q] <= aval_b(h_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			resv_q   <= '0;
		end else begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (v_s3) begin
				wr_ptr_q <= wr_ptr_q + OUT_AW'(1);
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + OUT_AW'(1);
			end
			case ({v_s3, pop_ok})
				2'b10:   cnt_q <= cnt_q + OUT_CW'(1);
				2'b01:   cnt_q <= cnt_q - OUT_CW'(1);
				default: cnt_q <= cnt_q;
			endcase
			case ({req.valid, pop_ok})
				2'b10:   resv_q <= resv_q + OUT_CW'(1);
				2'b01:   resv_q <= resv_q - OUT_CW'(1);
				default: resv_q <= resv_q;
			endcase
		end
	end

	`SFH_ASSERT_ALWAYS(a_resv_bound, resv_q <= OUT_CW'(OUT_DEPTH), "result slots overcommitted")
	`SFH_ASSERT_ALWAYS(a_queued_le_resv, cnt_q <= resv_q, "queued results exceed reserved slots")
	`SFH_ASSERT_ALWAYS(a_no_overflow, !v_s3 || cnt_q < OUT_CW'(OUT_DEPTH) || pop_ok, "result queue overflow")

endmodule

// ===== tb/tb_superfast_hash_32.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_superfast_hash_32
// Streams byte messages into the hash block and checks every popped hash
// against a cycle-free predictor, under several mixes of push and pop idling.
// ----------------------------------------------------------------------------
module tb_superfast_hash_32;

	localparam int PHASE_ITEMS = 488;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        start_req;
		logic [15:0] message_length;
	} hash_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  data_byte = 8'd0;
	logic        start_req = 1'b0;
	logic [15:0] message_length = 16'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [31:0] hash_value;

	hash_item_t  pending_items[$];
	logic [31:0] expected_hashes[$];

	// predictor state
	logic [31:0] hash_acc = 32'd0;
	logic [23:0] group_bytes = 24'd0;
	logic [15:0] bytes_left = 16'd0;
	logic [1:0]  group_fill = 2'd0;

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int cycle_count = 0;

	superfast_hash_32 u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.start_req      (start_req),
		.message_length (message_length),
		.empty          (empty),
		.pop            (pop),
		.hash_value     (hash_value)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// tail bytes plus avalanche
	function automatic logic [31:0] finalize_hash(input logic [31:0] h, input logic [23:0] held,
			input logic [1:0] fill);
		logic [31:0] x;
		x = h;
		if (fill == 2'd3) begin
			x += {16'd0, held[15:0]};
			x ^= x << 16;
			x ^= 32'($signed(held[23:16])) << 18;
			x += x >> 11;
		end else if (fill == 2'd2) begin
			x += {16'd0, held[15:0]};
			x ^= x << 11;
			x += x >> 17;
		end else if (fill == 2'd1) begin
			x += 32'($signed(held[7:0]));
			x ^= x << 10;
			x += x >> 1;
		end
		x ^= x << 3;
		x += x >> 5;
		x ^= x << 4;
		x += x >> 17;
		x ^= x << 25;
		x += x >> 6;
		return x;
	endfunction

	task automatic absorb_item(input hash_item_t it);
		logic [15:0] hi_half;
		logic [31:0] h;
		logic [31:0] t;
		if (it.start_req) begin
			group_bytes = 24'd0;
			group_fill = 2'd0;
			if (it.message_length == 16'd0) begin
				hash_acc = 32'd0;
				bytes_left = 16'd0;
				expected_hashes.push_back(32'd0);
				return;
			end
			hash_acc = {16'd0, it.message_length};
			bytes_left = it.message_length;
		end else if (bytes_left == 16'd0) begin
			return;
		end
		if (group_fill == 2'd3) begin
			hi_half = {it.data_byte, group_bytes[23:16]};
			h = hash_acc + {16'd0, group_bytes[15:0]};
			t = ({16'd0, hi_half} << 11) ^ h;
			h = (h << 16) ^ t;
			h += h >> 11;
			hash_acc = h;
			group_bytes = 24'd0;
			group_fill = 2'd0;
		end else begin
			group_bytes[8 * group_fill +: 8] = it.data_byte;
			group_fill = group_fill + 2'd1;
		end
		bytes_left = bytes_left - 16'd1;
		if (bytes_left == 16'd0) begin
			hash_acc = finalize_hash(hash_acc, group_bytes, group_fill);
			group_bytes = 24'd0;
			group_fill = 2'd0;
			expected_hashes.push_back(hash_acc);
		end
	endtask

	task automatic add_item(input logic [7:0] b, input logic s, input logic [15:0] len);
		hash_item_t it;
		it.data_byte = b;
		it.start_req = s;
		it.message_length = len;
		pending_items.push_back(it);
	endtask

	// start item plus count-1 further bytes, all random content
	task automatic add_message(input logic [15:0] len, input int count);
		add_item(8'($urandom), 1'b1, len);
		for (int i = 1; i < count; i++)
			add_item(8'($urandom), 1'b0, 16'($urandom));
	endtask

	function automatic logic [15:0] pick_length();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return 16'($urandom_range(12, 1));
		else if (r < 95)
			return 16'($urandom_range(64, 13));
		return 16'($urandom_range(400, 65));
	endfunction

	// driver: prediction is done on the edge that accepts the item
	always @(posedge clk) begin : item_driver
		hash_item_t it;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || !full) begin
			if (push) begin
				absorb_item('{data_byte, start_req, message_length});
			end
			if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
				it = pending_items.pop_front();
				push <= 1'b1;
				data_byte <= it.data_byte;
				start_req <= it.start_req;
				message_length <= it.message_length;
			end else begin
				push <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : hash_monitor
		logic [31:0] want;
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (expected_hashes.size() == 0) begin
					$display("%0t: hash_value expected none actual %08h", $time, hash_value);
					errors++;
				end else begin
					want = expected_hashes.pop_front();
					if (hash_value !== want) begin
						$display("%0t: hash_value expected %08h actual %08h", $time, want,
							hash_value);
						errors++;
					end
				end
			end
			pop <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("superfast_hash_32: mismatch");
			$finish;
		end
	end

	initial begin : stimulus
		int phase_items;
		int sel;
		int cnt;
		logic [15:0] len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			@(negedge clk);
			case (phase)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 48; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 48; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			phase_items = 0;
			if (phase == 0) begin
				add_item(8'hA5, 1'b1, 16'd0);      // zero length ignores its byte
				add_item(8'h3C, 1'b0, 16'hFFFF);   // stray byte while idle
				add_item(8'h80, 1'b1, 16'd1);      // lone negative byte
				add_item(8'h7F, 1'b1, 16'd1);
				add_item(8'hFF, 1'b1, 16'd2);
				add_item(8'h00, 1'b0, 16'd0);
				add_item(8'h00, 1'b1, 16'd3);
				add_item(8'hFF, 1'b0, 16'd0);
				add_item(8'h80, 1'b0, 16'd0);      // third tail byte sign-extended
				add_item(8'hFF, 1'b1, 16'd4);
				for (int i = 0; i < 3; i++)
					add_item(8'hFF, 1'b0, 16'd0);
				add_item(8'h01, 1'b1, 16'd5);
				add_item(8'h02, 1'b0, 16'd0);
				add_item(8'h03, 1'b0, 16'd0);
				add_item(8'h04, 1'b0, 16'd0);
				add_item(8'hFE, 1'b0, 16'd0);
				add_item(8'h55, 1'b1, 16'hFFFF);   // longest message, cut off by a restart
				add_item(8'hAA, 1'b0, 16'd0);
				add_item(8'h12, 1'b1, 16'd2);
				add_item(8'h34, 1'b0, 16'd0);
				phase_items = 22;
			end
			while (phase_items < PHASE_ITEMS) begin
				sel = $urandom_range(99);
				if (sel < 72) begin
					len = pick_length();
					add_message(len, int'(len));
					phase_items += int'(len);
				end else if (sel < 84) begin
					// partial message then a restart
					len = 16'($urandom_range(65535, 8));
					cnt = $urandom_range(7, 1);
					add_message(len, cnt);
					len = pick_length();
					add_message(len, int'(len));
					phase_items += cnt + int'(len);
				end else if (sel < 92) begin
					add_item(8'($urandom), 1'b1, 16'd0);
					phase_items++;
				end else begin
					cnt = $urandom_range(3, 1);
					for (int i = 0; i < cnt; i++)
						add_item(8'($urandom), 1'b0, 16'($urandom));
					phase_items += cnt;
				end
			end
			while (pending_items.size() != 0 || push)
				@(negedge clk);
		end
		while (expected_hashes.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("superfast_hash_32: match");
		else
			$display("superfast_hash_32: mismatch");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/sfh_pkg.sv
sv/sfh_front.sv
sv/sfh_mid_q.sv
sv/sfh_back.sv
sv/sfh_finish.sv
sv/superfast_hash_32.sv
tb/tb_superfast_hash_32.sv
